[design/sirl_pkg.sv]
// shared types, constants and codes of the sorted index range lookup
package sirl_pkg;

   localparam int DEF_TABLE_DEPTH = 1024;
   localparam int DEF_KEY_BITS    = 64;

   localparam int POS_W      = 10;
   localparam int COUNT_W    = 11;
   localparam int OFS_W      = 32;
   localparam int WIDE_W     = 17;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;

   localparam logic [0:0] CMD_WRITE  = 1'b0;
   localparam logic [0:0] CMD_LOOKUP = 1'b1;

   localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
   localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
   localparam logic [1:0] REG_ENTRIES    = 2'd2;
   localparam logic [1:0] REG_DATA_END   = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_COMPARE,
      ST_NEXT,
      ST_CAPTURE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic write_entry;
      logic lookup_start;
      logic set_miss;
      logic probe_first;
      logic probe_step;
      logic read_next;
      logic capture_end;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic hit;
      logic exhausted;
      logic hit_last;
   } status_type;

endpackage

[design/sorted_index_range_lookup.sv]
// top level of the sorted index range lookup
//
//   port group  dir     kind           carries
//   req_*       in      valid/ready    write or lookup word
//   rsp_*       out     valid/ready    found flag and offset pair of a lookup
//   csr_*       in/out  apb-style      key range, entries in use, data end
//
// a write word is done in the idle state; a lookup out of key range or on an empty table
// goes to the result state; one in range runs probe and compare, then next and capture
// on a hit below the last entry; at most ceil(log2(n + 1)) probes, each one memory read
// the probe loop is set by the single read port of the key and offset memories
// reset clears control and config only; table contents stay undefined until written
// a waiting result holds the sequencer in its result state; new words wait meanwhile
module sorted_index_range_lookup import sirl_pkg::*; #(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int KEY_BITS    = DEF_KEY_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [0:0]            req_cmd,
   input  logic [POS_W-1:0]      req_entry_position,
   input  logic [KEY_BITS-1:0]   req_entry_key,
   input  logic [OFS_W-1:0]      req_entry_offset,
   input  logic [KEY_BITS-1:0]   req_search_key,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_found,
   output logic [OFS_W-1:0]      rsp_start_ofs,
   output logic [OFS_W-1:0]      rsp_end_ofs,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [KEY_BITS-1:0] range_low_key;
   logic [KEY_BITS-1:0] range_high_key;
   logic [COUNT_W-1:0]  entries_in_use;
   logic [OFS_W-1:0]    data_end_ofs;
   cmd_type             cmd;
   status_type          status;

   sirl_csr #(
      .KEY_BITS (KEY_BITS)
   ) u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (csr_psel),
      .penable        (csr_penable),
      .pwrite         (csr_pwrite),
      .paddr          (csr_paddr),
      .pwdata         (csr_pwdata),
      .prdata         (csr_prdata),
      .pready         (csr_pready),
      .range_low_key  (range_low_key),
      .range_high_key (range_high_key),
      .entries_in_use (entries_in_use),
      .data_end_ofs   (data_end_ofs)
   );

   sirl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sirl_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS)
   ) u_dpath (
      .clock              (clock),
      .cmd                (cmd),
      .status             (status),
      .req_entry_position (req_entry_position),
      .req_entry_key      (req_entry_key),
      .req_entry_offset   (req_entry_offset),
      .req_search_key     (req_search_key),
      .range_low_key      (range_low_key),
      .range_high_key     (range_high_key),
      .entries_in_use     (entries_in_use),
      .data_end_ofs       (data_end_ofs),
      .rsp_found          (rsp_found),
      .rsp_start_ofs      (rsp_start_ofs),
      .rsp_end_ofs        (rsp_end_ofs)
   );

endmodule

[design/sirl_csr.sv]
// configuration registers behind the apb-style port
module sirl_csr import sirl_pkg::*; #(
   parameter int KEY_BITS = DEF_KEY_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [KEY_BITS-1:0]   range_low_key,
   output logic [KEY_BITS-1:0]   range_high_key,
   output logic [COUNT_W-1:0]    entries_in_use,
   output logic [OFS_W-1:0]      data_end_ofs
);

   logic [KEY_BITS-1:0] range_low_ff;
   logic [KEY_BITS-1:0] range_high_ff;
   logic [COUNT_W-1:0]  entries_ff;
   logic [OFS_W-1:0]    data_end_ff;
   logic [1:0]          reg_sel;
   logic                wr_en;

   assign reg_sel = paddr[4:3];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= '0;
         range_high_ff <= '0;
         entries_ff    <= '0;
         data_end_ff   <= '0;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_RANGE_LOW:  range_low_ff  <= pwdata[KEY_BITS-1:0];
            REG_RANGE_HIGH: range_high_ff <= pwdata[KEY_BITS-1:0];
            REG_ENTRIES:    entries_ff    <= pwdata[COUNT_W-1:0];
            REG_DATA_END:   data_end_ff   <= pwdata[OFS_W-1:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_RANGE_LOW:  prdata = CSR_DATA_W'(range_low_ff);
         REG_RANGE_HIGH: prdata = CSR_DATA_W'(range_high_ff);
         REG_ENTRIES:    prdata = CSR_DATA_W'(entries_ff);
         REG_DATA_END:   prdata = CSR_DATA_W'(data_end_ff);
         default:        prdata = '0;
      endcase
   end

   assign range_low_key  = range_low_ff;
   assign range_high_key = range_high_ff;
   assign entries_in_use = entries_ff;
   assign data_end_ofs   = data_end_ff;

endmodule

[design/sirl_ctrl.sv]
// lookup sequencer: accepts words, steps the search, hands off results
module sirl_ctrl import sirl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [0:0] req_cmd,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == CMD_WRITE) begin
                  cmd.write_entry = 1'b1;
               end else if (status.in_range) begin
                  cmd.lookup_start = 1'b1;
                  state_in         = ST_PROBE;
               end else begin
                  cmd.set_miss = 1'b1;
                  state_in     = ST_RESULT;
               end
            end
         end
         ST_PROBE: begin
            cmd.probe_first = 1'b1;
            state_in        = ST_COMPARE;
         end
         ST_COMPARE: begin
            cmd.probe_step = 1'b1;
            if (status.hit) begin
               state_in = status.hit_last ? ST_RESULT : ST_NEXT;
            end else if (status.exhausted) begin
               state_in = ST_RESULT;
            end
         end
         ST_NEXT: begin
            cmd.read_next = 1'b1;
            state_in      = ST_CAPTURE;
         end
         ST_CAPTURE: begin
            cmd.capture_end = 1'b1;
            state_in        = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

endmodule

[design/sirl_dpath.sv]
// table memories, search bounds, probe compare and result registers
module sirl_dpath import sirl_pkg::*; #(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int KEY_BITS    = DEF_KEY_BITS
) (
   input  logic                clock,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [POS_W-1:0]    req_entry_position,
   input  logic [KEY_BITS-1:0] req_entry_key,
   input  logic [OFS_W-1:0]    req_entry_offset,
   input  logic [KEY_BITS-1:0] req_search_key,
   input  logic [KEY_BITS-1:0] range_low_key,
   input  logic [KEY_BITS-1:0] range_high_key,
   input  logic [COUNT_W-1:0]  entries_in_use,
   input  logic [OFS_W-1:0]    data_end_ofs,
   output logic                rsp_found,
   output logic [OFS_W-1:0]    rsp_start_ofs,
   output logic [OFS_W-1:0]    rsp_end_ofs
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic [KEY_BITS-1:0] key_mem [TABLE_DEPTH];
   logic [OFS_W-1:0]    ofs_mem [TABLE_DEPTH];

   logic [KEY_BITS-1:0] key_ff;
   logic [KEY_BITS-1:0] key_rd_ff;
   logic [OFS_W-1:0]    ofs_rd_ff;
   logic [CNT_W-1:0]    n_ff;
   logic [CNT_W-1:0]    low_ff;
   logic [CNT_W-1:0]    high_ff;
   logic [IDX_W-1:0]    mid_ff;
   logic                found_ff;
   logic [OFS_W-1:0]    start_ff;
   logic [OFS_W-1:0]    end_ff;
   logic                rsp_found_ff;
   logic [OFS_W-1:0]    rsp_start_ff;
   logic [OFS_W-1:0]    rsp_end_ff;

   logic [WIDE_W-1:0]   pos_wide;
   logic [WIDE_W-1:0]   count_wide;
   logic                pos_ok;
   logic [IDX_W-1:0]    wr_idx;
   logic [CNT_W-1:0]    n_in;
   logic [CNT_W-1:0]    mid_w;
   logic [CNT_W-1:0]    low_up;
   logic [CNT_W-1:0]    high_dn;
   logic [CNT_W:0]      sum_first;
   logic [CNT_W:0]      sum_lt;
   logic [CNT_W:0]      sum_gt;
   logic                eq;
   logic                lt;
   logic                exhausted;
   logic                cont;
   logic [IDX_W-1:0]    rd_idx;
   logic                rd_en;

   assign pos_wide   = WIDE_W'(req_entry_position);
   assign pos_ok     = pos_wide < WIDE_W'(TABLE_DEPTH);
   assign wr_idx     = pos_wide[IDX_W-1:0];
   assign count_wide = WIDE_W'(entries_in_use);
   assign n_in       = (count_wide > WIDE_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                          : count_wide[CNT_W-1:0];

   assign mid_w     = CNT_W'(mid_ff);
   assign low_up    = mid_w + CNT_W'(1);
   assign high_dn   = mid_w - CNT_W'(1);
   assign sum_first = {1'b0, low_ff} + {1'b0, high_ff};
   assign sum_lt    = {1'b0, low_up} + {1'b0, high_ff};
   assign sum_gt    = {1'b0, low_ff} + {1'b0, high_dn};

   assign eq        = key_rd_ff == key_ff;
   assign lt        = key_rd_ff < key_ff;
   assign exhausted = !eq && (lt ? (low_up > high_ff) : (mid_w == low_ff));
   assign cont      = !eq && !exhausted;

   assign status.in_range  = (req_search_key >= range_low_key) &&
                             (req_search_key <= range_high_key) && (n_in != '0);
   assign status.hit       = eq;
   assign status.exhausted = exhausted;
   assign status.hit_last  = mid_w == (n_ff - CNT_W'(1));

   always_comb begin
      priority if (cmd.probe_first) begin
         rd_idx = sum_first[IDX_W:1];
      end else if (cmd.read_next) begin
         rd_idx = mid_ff + IDX_W'(1);
      end else if (lt) begin
         rd_idx = sum_lt[IDX_W:1];
      end else begin
         rd_idx = sum_gt[IDX_W:1];
      end
   end

   assign rd_en = cmd.probe_first | cmd.read_next | (cmd.probe_step & cont);

   always_ff @(posedge clock) begin
      if (cmd.write_entry && pos_ok) begin
         key_mem[wr_idx] <= req_entry_key;
         ofs_mem[wr_idx] <= req_entry_offset;
      end
      if (rd_en) begin
         key_rd_ff <= key_mem[rd_idx];
         ofs_rd_ff <= ofs_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup_start) begin
         key_ff  <= req_search_key;
         n_ff    <= n_in;
         low_ff  <= '0;
         high_ff <= n_in - CNT_W'(1);
      end else if (cmd.probe_step && cont) begin
         if (lt) begin
            low_ff <= low_up;
         end else begin
            high_ff <= high_dn;
         end
      end
      if (cmd.probe_first || (cmd.probe_step && cont)) begin
         mid_ff <= rd_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set_miss || (cmd.probe_step && exhausted)) begin
         found_ff <= 1'b0;
         start_ff <= '0;
         end_ff   <= '0;
      end else if (cmd.probe_step && eq) begin
         found_ff <= 1'b1;
         start_ff <= ofs_rd_ff;
         if (status.hit_last) begin
            end_ff <= data_end_ofs;
         end
      end else if (cmd.capture_end) begin
         end_ff <= ofs_rd_ff;
      end
      if (cmd.rsp_load) begin
         rsp_found_ff <= found_ff;
         rsp_start_ff <= start_ff;
         rsp_end_ff   <= end_ff;
      end
   end

   assign rsp_found     = rsp_found_ff;
   assign rsp_start_ofs = rsp_start_ff;
   assign rsp_end_ofs   = rsp_end_ff;

endmodule

[test/sorted_index_range_lookup_tb.sv]
// self-checking testbench for the sorted index range lookup, with directed and random words
`timescale 1ns / 100ps

module sorted_index_range_lookup_tb;
   import sirl_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 32;
   localparam int RANDOM_WORDS = 700;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic [0:0]       cmd;
      logic [POS_W-1:0] position;
      logic [63:0]      entry_key;
      logic [OFS_W-1:0] entry_offset;
      logic [63:0]      search_key;
   } req_word_type;

   typedef struct packed {
      logic             found;
      logic [OFS_W-1:0] start_ofs;
      logic [OFS_W-1:0] end_ofs;
   } lookup_result_type;

   class lookup_checker;
      logic [63:0]        key_mem [DEF_TABLE_DEPTH];
      logic [OFS_W-1:0]   ofs_mem [DEF_TABLE_DEPTH];
      logic [63:0]        low_key = '0;
      logic [63:0]        high_key = '0;
      logic [COUNT_W-1:0] entry_count = '0;
      logic [OFS_W-1:0]   data_end = '0;
      lookup_result_type  pending_lookups [$];
      int                 errors = 0;

      function void set_reg(logic [1:0] idx, logic [63:0] value);
         case (idx)
            REG_RANGE_LOW: low_key = value;
            REG_RANGE_HIGH: high_key = value;
            REG_ENTRIES: entry_count = value[COUNT_W-1:0];
            REG_DATA_END: data_end = value[OFS_W-1:0];
            default: ;
         endcase
      endfunction

      function lookup_result_type search_table(logic [63:0] key);
         lookup_result_type r;
         int n, lo, hi, mid;
         r = '0;
         n = (entry_count > DEF_TABLE_DEPTH) ? DEF_TABLE_DEPTH : int'(entry_count);
         if (key >= low_key && key <= high_key && n > 0) begin
            lo = 0;
            hi = n - 1;
            while (lo <= hi) begin
               mid = (lo + hi) / 2;
               if (key_mem[mid] == key) begin
                  r.found = 1'b1;
                  r.start_ofs = ofs_mem[mid];
                  r.end_ofs = (mid == n - 1) ? data_end : ofs_mem[mid + 1];
                  break;
               end else if (key_mem[mid] < key) begin
                  lo = mid + 1;
               end else begin
                  if (mid == 0)
                     break;
                  hi = mid - 1;
               end
            end
         end
         return r;
      endfunction

      function void note_word(req_word_type w);
         if (w.cmd == CMD_WRITE) begin
            key_mem[w.position] = w.entry_key;
            ofs_mem[w.position] = w.entry_offset;
         end else begin
            pending_lookups.push_back(search_table(w.search_key));
         end
      endfunction

      function void flag(string what, logic [63:0] want, logic [63:0] got);
         errors++;
         if (errors <= 10)
            $display("mismatch in %s: expected %0h, got %0h", what, want, got);
      endfunction

      function void check_result(lookup_result_type got);
         lookup_result_type want;
         if (pending_lookups.size() == 0) begin
            flag("unexpected result word, found", 0, got.found);
            return;
         end
         want = pending_lookups.pop_front();
         if (got.found !== want.found)
            flag("found", want.found, got.found);
         if (got.start_ofs !== want.start_ofs)
            flag("start_ofs", want.start_ofs, got.start_ofs);
         if (got.end_ofs !== want.end_ofs)
            flag("end_ofs", want.end_ofs, got.end_ofs);
      endfunction

      function int pending();
         return pending_lookups.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [0:0]            req_cmd = CMD_WRITE;
   logic [POS_W-1:0]      req_entry_position = '0;
   logic [63:0]           req_entry_key = '0;
   logic [OFS_W-1:0]      req_entry_offset = '0;
   logic [63:0]           req_search_key = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_found;
   logic [OFS_W-1:0]      rsp_start_ofs;
   logic [OFS_W-1:0]      rsp_end_ofs;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   lookup_checker sb;
   bit            idle_on = 1'b0;
   int            words_sent = 0;
   int            stall_left = 0;
   int            quiet = 0;
   logic [63:0]   loaded_keys [DEF_TABLE_DEPTH];
   int            loaded_count = 1;

   sorted_index_range_lookup uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_entry_position(req_entry_position),
      .req_entry_key(req_entry_key),
      .req_entry_offset(req_entry_offset),
      .req_search_key(req_search_key),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_found(rsp_found),
      .rsp_start_ofs(rsp_start_ofs),
      .rsp_end_ofs(rsp_end_ofs),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 13) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_word('{req_cmd, req_entry_position, req_entry_key, req_entry_offset,
                           req_search_key});
         if (rsp_valid && rsp_ready)
            sb.check_result('{rsp_found, rsp_start_ofs, rsp_end_ofs});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet <= 0;
      end else if (quiet + 1 >= QUIET_LIMIT) begin
         $display("sorted_index_range_lookup_tb: FAIL");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic send_word(input req_word_type w);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 13);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= w.cmd;
      req_entry_position <= w.position;
      req_entry_key <= w.entry_key;
      req_entry_offset <= w.entry_offset;
      req_search_key <= w.search_key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   // unused fields carry junk
   task automatic put_entry(input logic [POS_W-1:0] pos, input logic [63:0] key,
                            input logic [OFS_W-1:0] ofs);
      send_word('{CMD_WRITE, pos, key, ofs, {$urandom, $urandom}});
   endtask

   task automatic seek(input logic [63:0] key);
      send_word('{CMD_LOOKUP, POS_W'($urandom), {$urandom, $urandom}, OFS_W'($urandom), key});
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(int'(idx) * 8);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      sb.set_reg(idx, value);
   endtask

   // registers change only once the block has gone quiet
   task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [COUNT_W-1:0] count, input logic [OFS_W-1:0] dend);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(REG_RANGE_LOW, lo);
      csr_write(REG_RANGE_HIGH, hi);
      csr_write(REG_ENTRIES, 64'(count));
      csr_write(REG_DATA_END, 64'(dend));
   endtask

   task automatic lookup_burst(input int looks);
      int i, kind;
      logic [63:0] k;
      for (i = 0; i < looks; i++) begin
         kind = $urandom_range(0, 19);
         k = loaded_keys[$urandom_range(0, loaded_count - 1)];
         case (kind)
            12, 13: k = $urandom_range(0, 1) ? k + 1 : k - 1;
            14, 15: k = {$urandom, $urandom};
            16: k = $urandom_range(0, 1) ? sb.low_key : sb.high_key;
            17: k = $urandom_range(0, 1) ? sb.low_key - 1 : sb.high_key + 1;
            default: ;
         endcase
         if (kind >= 18)
            put_entry(POS_W'($urandom), {$urandom, $urandom}, $urandom);
         else
            seek(k);
      end
   endtask

   task automatic table_round();
      int n, shift, i, mode;
      logic [63:0] k, lo, hi;
      logic [COUNT_W-1:0] count;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
      shift = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(41, 63);
      k = {$urandom, $urandom} >> $urandom_range(0, 63);
      for (i = 0; i < n; i++) begin
         loaded_keys[i] = k;
         put_entry(POS_W'(i), k, $urandom);
         k = k + ({$urandom, $urandom} >> shift);
      end
      loaded_count = n;
      mode = $urandom_range(0, 3);
      case (mode)
         2: begin
            lo = loaded_keys[0];
            hi = loaded_keys[n - 1];
         end
         3: begin
            lo = loaded_keys[$urandom_range(0, n - 1)];
            hi = loaded_keys[$urandom_range(0, n - 1)];
         end
         default: begin
            lo = '0;
            hi = ALL_ONES;
         end
      endcase
      case ($urandom_range(0, 15))
         0, 1: count = COUNT_W'($urandom_range(0, n));
         2: count = COUNT_W'($urandom_range(n, DEF_TABLE_DEPTH));
         default: count = COUNT_W'(n);
      endcase
      set_config(lo, hi, count, $urandom);
      lookup_burst($urandom_range(10, 40));
   endtask

   initial begin
      int i, stop_at;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty table right after reset
      seek('0);
      put_entry(POS_W'(0), '0, '0);
      put_entry(POS_W'(1), 64'd5, 32'd100);
      put_entry(POS_W'(2), 64'h100, 32'd200);
      put_entry(POS_W'(3), 64'h8000_0000_0000_0000, 32'hFFFF_FFFF);
      put_entry(POS_W'(4), ALL_ONES - 1, 32'd300);
      put_entry(POS_W'(5), ALL_ONES, 32'd400);
      put_entry(POS_W'(1023), 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
      set_config('0, ALL_ONES, 11'd6, 32'hFFFF_FFFF);
      seek('0);
      seek(ALL_ONES);
      seek(64'd5);
      seek(64'h8000_0000_0000_0000);
      seek(64'd3);
      seek(ALL_ONES - 1);
      // search runs off below position zero
      put_entry(POS_W'(0), 64'd2, 32'd7);
      seek(64'd1);
      seek(64'd2);
      set_config(64'd6, ALL_ONES - 1, 11'd6, '0);
      seek(64'd5);
      seek(ALL_ONES);
      seek(64'h100);
      seek(64'd6);
      set_config('0, ALL_ONES, 11'd1, 32'h1234);
      seek(64'd2);

      // whole table, then counts at and beyond the depth
      idle_on = 1'b1;
      for (i = 0; i < DEF_TABLE_DEPTH; i++) begin
         loaded_keys[i] = {POS_W'(i), 54'({$urandom, $urandom})};
         put_entry(POS_W'(i), loaded_keys[i], $urandom);
      end
      loaded_count = DEF_TABLE_DEPTH;
      set_config('0, ALL_ONES, 11'(DEF_TABLE_DEPTH), $urandom);
      lookup_burst(40);
      seek(loaded_keys[DEF_TABLE_DEPTH - 1]);
      set_config('0, ALL_ONES, 11'h7FF, $urandom);
      seek(loaded_keys[DEF_TABLE_DEPTH - 1]);
      lookup_burst(10);
      set_config('0, ALL_ONES, 11'($urandom_range(DEF_TABLE_DEPTH + 1, 2046)), $urandom);
      lookup_burst(10);

      stop_at = words_sent + RANDOM_WORDS;
      while (words_sent < stop_at) begin
         idle_on = (words_sent < stop_at - 360) && ($urandom_range(0, 4) != 0);
         table_round();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("sorted_index_range_lookup_tb: PASS");
      else
         $display("sorted_index_range_lookup_tb: FAIL");
      $finish;
   end

endmodule

[filelist.f]
design/sirl_pkg.sv
design/sirl_csr.sv
design/sirl_ctrl.sv
design/sirl_dpath.sv
design/sorted_index_range_lookup.sv
test/sorted_index_range_lookup_tb.sv
